// ===== rtl/bmac_pkg.sv =====
package bmac_pkg;

	localparam int IN_W     = 32;
	localparam int LANES    = 3;
	localparam int S_DATA_W = 2 * LANES * IN_W;
	localparam int CLASS_W  = 2;
	localparam int M_DATA_W = 8;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_RELAXED   = 2'd0,
		CLASS_FOCUSED   = 2'd1,
		CLASS_WANDERING = 2'd2
	} class_t;

	// per-cycle commands from the sequencer to the rank lanes
	typedef struct packed {
		logic start;
		logic load_cand;
		logic count;
		logic eval;
	} rank_ctl_t;

endpackage

// ===== rtl/bmac_win_mem.sv =====
module bmac_win_mem #(
	parameter int DEPTH = 62,
	parameter int AW    = 6,
	parameter int SW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [SW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [SW-1:0] rdata
);

	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bmac_rank_lane.sv =====
module bmac_rank_lane #(
	parameter int SW = 32,
	parameter int CW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bmac_pkg::rank_ctl_t ctl,
	input  logic [SW-1:0]       rd_data,
	input  logic [CW-1:0]       rank,
	output logic                done,
	output logic [SW-1:0]       median
);

	logic [SW-1:0] cand_q;
	logic [SW-1:0] med_q;
	logic [CW-1:0] below_q;
	logic [CW-1:0] upto_q;
	logic          found_q;
	logic          hit;

	// candidate sits at the wanted rank when fewer are below and more are at or below
	assign hit    = (below_q <= rank) && (rank < upto_q);
	assign done   = found_q || hit;
	assign median = med_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			below_q <= '0;
			upto_q  <= '0;
		end else begin
			if (ctl.start) begin
				found_q <= 1'b0;
			end
			if (ctl.load_cand) begin
				below_q <= '0;
				upto_q  <= '0;
			end else if (ctl.count) begin
				if (rd_data < cand_q) begin
					below_q <= below_q + CW'(1);
				end
				if (rd_data <= cand_q) begin
					upto_q <= upto_q + CW'(1);
				end
			end
			if (ctl.eval && !found_q && hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_cand) begin
			cand_q <= rd_data;
		end
		if (ctl.eval && !found_q && hit) begin
			med_q <= cand_q;
		end
	end

endmodule

// ===== rtl/band_median_argmax_classifier.sv =====
// each accepted request is written to the window, then candidates are tried until every band
// has its median; n = samples held per band (2 up to 2*WINDOW_FRAMES, 62 at the default
// window), candidates tried <= n; one request is worked at a time
// a result that stalls holds off the next request; the compare-and-count pass reads one
// window entry per cycle per band
// reset clears fill count, pair pointer and handshakes; window memories are not cleared
module band_median_argmax_classifier #(
	parameter int WINDOW_FRAMES = 31,
	parameter int SAMPLE_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// alpha_first, alpha_second, low_beta_first, low_beta_second,
	// high_beta_first, high_beta_second
	input  logic [bmac_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mental_class
	output logic [bmac_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int DEPTH = 2 * WINDOW_FRAMES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SLW   = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
	localparam int SW    = SAMPLE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WR0, ST_WR1, ST_FETCH, ST_CAND, ST_SCAN, ST_EVAL, ST_CMP
	} state_t;

	state_t                        state_q;
	logic [bmac_pkg::S_DATA_W-1:0] in_q;
	logic [CW-1:0]                 n_q;
	logic [SLW-1:0]                old_q;
	logic [SLW-1:0]                slot_q;
	logic [AW-1:0]                 i_q;
	logic [CW-1:0]                 j_q;
	logic                          m_tvalid_q;
	bmac_pkg::class_t              class_q;

	bmac_pkg::rank_ctl_t ctl;
	logic                we;
	logic                wr_hi;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [CW-1:0]       rank;
	logic [SW-1:0]       lane_rd  [bmac_pkg::LANES];
	logic [SW-1:0]       lane_med [bmac_pkg::LANES];
	logic [bmac_pkg::LANES-1:0] lane_done;
	logic                s_fire;
	logic                out_free;
	logic                last_cand;
	bmac_pkg::class_t    cls;
	logic [SW-1:0]       best;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = bmac_pkg::M_DATA_W'(class_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign rank      = {1'b0, n_q[CW-1:1]};
	assign last_cand = ((CW'(i_q) + CW'(1)) == n_q);

	assign wr_hi = (state_q == ST_WR1);
	assign we    = (state_q == ST_WR0) || wr_hi;
	assign waddr = AW'({slot_q, wr_hi});

	always_comb begin
		case (state_q)
			ST_CAND: raddr = '0;
			ST_SCAN: raddr = j_q[AW-1:0];
			default: raddr = i_q;
		endcase
	end

	always_comb begin
		ctl.start     = (state_q == ST_WR0);
		ctl.load_cand = (state_q == ST_CAND);
		ctl.count     = (state_q == ST_SCAN);
		ctl.eval      = (state_q == ST_EVAL);
	end

	for (genvar k = 0; k < bmac_pkg::LANES; k++) begin : g_lane
		logic [SW-1:0] wdata;

		assign wdata = wr_hi ? SW'(in_q[2*k*bmac_pkg::IN_W + bmac_pkg::IN_W +: bmac_pkg::IN_W])
		                     : SW'(in_q[2*k*bmac_pkg::IN_W +: bmac_pkg::IN_W]);

		bmac_win_mem #(
			.DEPTH (DEPTH),
			.AW    (AW),
			.SW    (SW)
		) u_mem (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.raddr (raddr),
			.rdata (lane_rd[k])
		);

		bmac_rank_lane #(
			.SW (SW),
			.CW (CW)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.rd_data (lane_rd[k]),
			.rank    (rank),
			.done    (lane_done[k]),
			.median  (lane_med[k])
		);
	end

	// earlier band wins ties: alpha, then low beta, then high beta
	always_comb begin
		cls  = bmac_pkg::CLASS_RELAXED;
		best = lane_med[0];
		if (lane_med[1] > lane_med[0]) begin
			cls  = bmac_pkg::CLASS_WANDERING;
			best = lane_med[1];
		end
		if (lane_med[2] > best) begin
			cls = bmac_pkg::CLASS_FOCUSED;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			in_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			old_q      <= '0;
			slot_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			m_tvalid_q <= 1'b0;
			class_q    <= bmac_pkg::CLASS_RELAXED;
		end else begin
			// a new result in the same cycle keeps valid high
			if (m_tvalid_q && m_tready && !((state_q == ST_CMP) && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (n_q < CW'(DEPTH)) begin
							slot_q <= SLW'(n_q[CW-1:1]);
							n_q    <= n_q + CW'(2);
						end else begin
							slot_q <= old_q;
							old_q  <= (old_q == SLW'(WINDOW_FRAMES - 1)) ? '0 : old_q + SLW'(1);
						end
						state_q <= ST_WR0;
					end
				end
				ST_WR0: begin
					state_q <= ST_WR1;
				end
				ST_WR1: begin
					i_q     <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_CAND;
				end
				ST_CAND: begin
					j_q     <= CW'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// read data is registered and arrives in the cycle after its address
					if (j_q == n_q) begin
						state_q <= ST_EVAL;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_EVAL: begin
					if ((&lane_done) || last_cand) begin
						state_q <= ST_CMP;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_CMP: begin
					if (out_free) begin
						class_q    <= cls;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
